// File: rtl/i2cbm_pkg.sv
// Package for the I2C byte master engine: command codes, phase encoding,
// configuration and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned TIMER_W         = 12;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned BIT_IDX_W       = 4;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned RECOVERY_PULSES = 9;

    localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET = 12'd25;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET     = 12'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_TIMEOUT     = 2'd1
    } t_reg_idx;

    typedef enum logic [OP_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4,
        CMD_RECOVER = 3'd5
    } t_cmd;

    typedef enum logic [13:0] {
        PH_IDLE        = 14'b00000000000001,
        PH_START_WAIT  = 14'b00000000000010,
        PH_START_HOLD1 = 14'b00000000000100,
        PH_START_HOLD2 = 14'b00000000001000,
        PH_STOP_SETUP  = 14'b00000000010000,
        PH_STOP_WAIT   = 14'b00000000100000,
        PH_STOP_HIGH   = 14'b00000001000000,
        PH_STOP_FREE   = 14'b00000010000000,
        PH_BIT_SETUP   = 14'b00000100000000,
        PH_BIT_WAIT    = 14'b00001000000000,
        PH_BIT_HIGH    = 14'b00010000000000,
        PH_REC_LOW     = 14'b00100000000000,
        PH_REC_WAIT    = 14'b01000000000000,
        PH_REC_HIGH    = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        logic [TIMER_W-1:0] half_period_ticks;
        logic [TIMER_W-1:0] stretch_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              scl_pull_low;
        logic              sda_pull_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
        logic              error_code;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/i2cbm_ifs.sv
// Valid/ready channel interfaces for the I2C byte master engine: tick
// requests, results and configuration writes. Depends on i2cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface i2cbm_req_if;
    import i2cbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              scl_level;
    logic              sda_level;

    modport source (output valid, op, tx_byte, send_ack, scl_level, sda_level,
                    input ready);
    modport sink   (input valid, op, tx_byte, send_ack, scl_level, sda_level,
                    output ready);
endinterface

interface i2cbm_res_if;
    import i2cbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
    logic              error_code;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    rx_byte, ack_seen, error_code, input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    rx_byte, ack_seen, error_code, output ready);
endinterface

interface i2cbm_cfg_if;
    import i2cbm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIMER_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2cbm_cfg.sv
// Configuration registers of the I2C byte master engine.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [i2cbm_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [i2cbm_pkg::TIMER_W-1:0]   i_data,
    output i2cbm_pkg::t_cfg                      o_cfg
);
    import i2cbm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks     <= HALF_PERIOD_RESET;
            r_cfg.stretch_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_wr) begin
            case (t_reg_idx'(i_index))
                REG_HALF_PERIOD: r_cfg.half_period_ticks     <= i_data;
                REG_TIMEOUT:     r_cfg.stretch_timeout_ticks <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/i2cbm_core.sv
// Bit engine state machine: one accepted tick advances the phase, timer,
// shift register and line drives and forms that tick's result. Depends on i2cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_core #(
    parameter int unsigned RECOVERY_PULSES = i2cbm_pkg::RECOVERY_PULSES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [i2cbm_pkg::OP_W-1:0]   i_op,
    input  wire logic [i2cbm_pkg::BYTE_W-1:0] i_tx_byte,
    input  wire logic                        i_send_ack,
    input  wire logic                        i_scl_level,
    input  wire logic                        i_sda_level,
    input  wire i2cbm_pkg::t_cfg              i_cfg,
    output i2cbm_pkg::t_result                o_result
);
    import i2cbm_pkg::*;

    localparam int unsigned PULSE_W = $clog2(RECOVERY_PULSES + 1);
    localparam logic [PULSE_W-1:0] LAST_PULSE = PULSE_W'(RECOVERY_PULSES);

    t_phase               r_phase,   n_phase;
    t_cmd                 r_cmd,     n_cmd;
    logic [TIMER_W-1:0]   r_timer,   n_timer;
    logic [BIT_IDX_W-1:0] r_bit,     n_bit;
    logic [BYTE_W-1:0]    r_shift,   n_shift;
    logic [PULSE_W-1:0]   r_pulse,   n_pulse;
    logic                 r_scl,     n_scl;
    logic                 r_sda,     n_sda;
    logic                 r_ack_lat, n_ack_lat;
    logic [BYTE_W-1:0]    r_rx,      n_rx;
    logic                 r_ack,     n_ack;

    logic [TIMER_W-1:0] t_inc;
    logic               dly_over;
    logic               to_over;
    logic               done;
    logic               err;
    logic [PULSE_W-1:0] pulse_inc;

    assign t_inc     = r_timer + TIMER_W'(1);
    assign dly_over  = (t_inc >= i_cfg.half_period_ticks);
    assign to_over   = (t_inc >= i_cfg.stretch_timeout_ticks);
    assign pulse_inc = r_pulse + PULSE_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_timer   = r_timer;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_pulse   = r_pulse;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack_lat = r_ack_lat;
        n_rx      = r_rx;
        n_ack     = r_ack;
        done      = 1'b0;
        err       = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                n_timer = '0;
                case (t_cmd'(i_op))
                    CMD_START: begin
                        n_sda   = 1'b0;
                        n_scl   = 1'b0;
                        n_cmd   = CMD_START;
                        n_phase = PH_START_WAIT;
                    end
                    CMD_STOP: begin
                        n_sda   = 1'b1;
                        n_cmd   = CMD_STOP;
                        n_phase = PH_STOP_SETUP;
                    end
                    CMD_WRITE: begin
                        n_cmd     = CMD_WRITE;
                        n_shift   = i_tx_byte;
                        n_ack_lat = i_send_ack;
                        n_bit     = '0;
                        n_sda     = ~i_tx_byte[BYTE_W-1];
                        n_phase   = PH_BIT_SETUP;
                    end
                    CMD_READ: begin
                        n_cmd     = CMD_READ;
                        n_shift   = '0;
                        n_ack_lat = i_send_ack;
                        n_bit     = '0;
                        n_sda     = 1'b0;
                        n_phase   = PH_BIT_SETUP;
                    end
                    CMD_RECOVER: begin
                        n_sda   = 1'b0;
                        n_scl   = 1'b1;
                        n_pulse = '0;
                        n_cmd   = CMD_RECOVER;
                        n_phase = PH_REC_LOW;
                    end
                    default: ;
                endcase
            end
            PH_START_WAIT: begin
                if (i_scl_level) begin
                    n_timer = '0;
                    n_phase = PH_START_HOLD1;
                end else if (to_over) begin
                    n_timer = '0;
                    done    = 1'b1;
                    err     = 1'b1;
                end else begin
                    n_timer = t_inc;
                end
            end
            PH_START_HOLD1: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_sda   = 1'b1;
                    n_phase = PH_START_HOLD2;
                end
            end
            PH_START_HOLD2: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_scl = 1'b1;
                    done  = 1'b1;
                end
            end
            PH_STOP_SETUP: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_STOP_WAIT;
                end
            end
            PH_STOP_WAIT: begin
                if (i_scl_level || to_over) begin
                    n_timer = '0;
                    n_phase = PH_STOP_HIGH;
                end else begin
                    n_timer = t_inc;
                end
            end
            PH_STOP_HIGH: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_sda   = 1'b0;
                    n_phase = PH_STOP_FREE;
                end
            end
            PH_STOP_FREE: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    done = 1'b1;
                end
            end
            PH_BIT_SETUP: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_BIT_WAIT;
                end
            end
            PH_BIT_WAIT: begin
                if (i_scl_level) begin
                    n_timer = '0;
                    n_phase = PH_BIT_HIGH;
                end else if (to_over) begin
                    n_timer = '0;
                    if (r_cmd == CMD_WRITE) begin
                        n_ack = 1'b0;
                    end
                    done = 1'b1;
                    err  = 1'b1;
                end else begin
                    n_timer = t_inc;
                end
            end
            PH_BIT_HIGH: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_scl = 1'b1;
                    if (!r_bit[BIT_IDX_W-1]) begin
                        n_shift = {r_shift[BYTE_W-2:0],
                                   (r_cmd == CMD_READ) ? i_sda_level : 1'b0};
                        n_bit   = r_bit + BIT_IDX_W'(1);
                        if (!n_bit[BIT_IDX_W-1]) begin
                            n_sda = (r_cmd == CMD_WRITE) ? ~n_shift[BYTE_W-1] : 1'b0;
                        end else begin
                            n_sda = (r_cmd == CMD_READ) ? r_ack_lat : 1'b0;
                        end
                        n_phase = PH_BIT_SETUP;
                    end else begin
                        if (r_cmd == CMD_WRITE) begin
                            n_ack = ~i_sda_level;
                        end else begin
                            n_rx = r_shift;
                        end
                        done = 1'b1;
                    end
                end
            end
            PH_REC_LOW: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_REC_WAIT;
                end
            end
            PH_REC_WAIT: begin
                if (i_scl_level || to_over) begin
                    n_timer = '0;
                    n_phase = PH_REC_HIGH;
                end else begin
                    n_timer = t_inc;
                end
            end
            PH_REC_HIGH: begin
                n_timer = dly_over ? '0 : t_inc;
                if (dly_over) begin
                    n_pulse = pulse_inc;
                    if (pulse_inc < LAST_PULSE) begin
                        n_scl   = 1'b1;
                        n_phase = PH_REC_LOW;
                    end else begin
                        n_sda   = 1'b1;
                        n_phase = PH_STOP_SETUP;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cmd   = CMD_NONE;
            end
        endcase

        if (done) begin
            n_phase = PH_IDLE;
            n_cmd   = CMD_NONE;
            n_timer = '0;
        end
    end

    always_comb begin
        o_result.scl_pull_low = n_scl;
        o_result.sda_pull_low = n_sda;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.rx_byte      = n_rx;
        o_result.ack_seen     = n_ack;
        o_result.error_code   = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= CMD_NONE;
            r_timer   <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_pulse   <= '0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
            r_ack_lat <= 1'b0;
            r_rx      <= '0;
            r_ack     <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_timer   <= n_timer;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_pulse   <= n_pulse;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_ack_lat <= n_ack_lat;
            r_rx      <= n_rx;
            r_ack     <= n_ack;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2cbm_out_buf.sv
// Result register with a skid stage so that ticks keep flowing while a
// result waits to be taken. Depends on i2cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_out_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire i2cbm_pkg::t_result i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output i2cbm_pkg::t_result o_data
);
    import i2cbm_pkg::*;

    logic    r_o_valid;
    logic    r_s_valid;
    t_result r_o_data;
    t_result r_s_data;
    logic    pop;

    assign pop     = r_o_valid && i_ready;
    assign o_ready = !r_s_valid;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (pop) begin
            if (r_s_valid) begin
                r_s_valid <= 1'b0;
            end else begin
                r_o_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_o_valid) begin
                r_o_valid <= 1'b1;
            end else begin
                r_s_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_data <= r_s_valid ? r_s_data : i_data;
        end else if (i_push) begin
            if (!r_o_valid) begin
                r_o_data <= i_data;
            end else begin
                r_s_data <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2c_byte_master_engine_top.sv
// Top level of the I2C byte master engine: configuration registers, bit
// engine and result buffer. Depends on i2cbm_pkg, i2cbm_ifs and the i2cbm modules.
//
// Each request is one timebase tick carrying the sampled SCL and SDA levels
// and an optional command (start, stop, write byte, read byte, recover);
// commands are taken only while the engine is idle. Every request yields
// exactly one result with the open-drain drives, busy, done, the last read
// byte, the last acknowledge and the stuck-clock error flag. A request is taken
// every cycle unless the skid stage is full; the state advances once per accepted
// tick, and a result register plus a skid stage keep the request side ready while
// one result waits. Half-bit length and stretch timeout are in ticks; the user must
// write them only while idle (not enforced) through the always-ready config channel.
`timescale 1ns / 1ps
`default_nettype none

module i2c_byte_master_engine_top #(
    parameter int unsigned RECOVERY_PULSES = i2cbm_pkg::RECOVERY_PULSES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cbm_req_if.sink   i_req,
    i2cbm_res_if.source o_res,
    i2cbm_cfg_if.sink   i_cfg
);
    import i2cbm_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result buf_res;
    logic    req_ready;
    logic    req_accept;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;
    assign req_accept  = i_req.valid && req_ready;

    i2cbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    i2cbm_core #(
        .RECOVERY_PULSES (RECOVERY_PULSES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (req_accept),
        .i_op        (i_req.op),
        .i_tx_byte   (i_req.tx_byte),
        .i_send_ack  (i_req.send_ack),
        .i_scl_level (i_req.scl_level),
        .i_sda_level (i_req.sda_level),
        .i_cfg       (cfg),
        .o_result    (core_res)
    );

    i2cbm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_accept),
        .i_data  (core_res),
        .o_ready (req_ready),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (buf_res)
    );

    assign o_res.scl_pull_low = buf_res.scl_pull_low;
    assign o_res.sda_pull_low = buf_res.sda_pull_low;
    assign o_res.busy_res     = buf_res.busy_res;
    assign o_res.done_res     = buf_res.done_res;
    assign o_res.rx_byte      = buf_res.rx_byte;
    assign o_res.ack_seen     = buf_res.ack_seen;
    assign o_res.error_code   = buf_res.error_code;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.busy_res)
        else $error("done result still reports busy");

    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.error_code |-> o_res.done_res)
        else $error("error flag without done");

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_ready |-> o_res.valid)
        else $error("request side stalled with no result pending");

    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept && !core_res.busy_res && !core_res.done_res |=> o_res.valid)
        else $error("accepted request produced no result");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the I2C byte master engine: drives timebase ticks
// that follow a modeled bus, predicts every result and compares field by field.
// Depends on i2cbm_pkg, the i2cbm channel interfaces and i2c_byte_master_engine_top.
`timescale 1ns / 1ps

module tb_top;
    import i2cbm_pkg::*;

    localparam logic [OP_W-1:0]      OP_RSVD6    = 3'd6;
    localparam logic [OP_W-1:0]      OP_RSVD7    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED3 = 2'd3;
    localparam int                   NO_STUCK    = -1;

    typedef enum logic [1:0] {
        SCL_STILL_LOW,
        SCL_WENT_HIGH,
        SCL_TIMED_OUT
    } t_scl_wait;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              scl_level;
        logic              sda_level;
    } t_tick;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx;
        logic              ack;
        int                stuck_wait;
        int                gap;
    } t_cmd_req;

    logic clk;
    logic rst_n;

    i2cbm_req_if req_if ();
    i2cbm_res_if res_if ();
    i2cbm_cfg_if cfg_if ();

    i2c_byte_master_engine_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // engine image
    t_phase             eng_phase;
    logic [TIMER_W-1:0] eng_timer;
    logic [3:0]         eng_bit;
    logic [7:0]         eng_shift;
    logic [3:0]         eng_pulse;
    t_cmd               eng_cmd;
    logic               eng_scl_low;
    logic               eng_sda_low;
    logic               eng_ack_latch;
    logic [7:0]         eng_rx;
    logic               eng_ack_seen;
    logic [TIMER_W-1:0] half_ticks;
    logic [TIMER_W-1:0] stretch_limit;

    t_tick    bus_ticks[$];
    t_result  due_outputs[$];
    t_cmd_req cmd_plan[$];

    int      issued;
    int      accepted;
    int      res_count;
    int      fail_cnt;
    int      gen_ticks;
    bit      no_idle;
    int      gap_left;
    int      stretch_left;
    int      stuck_at;
    int      waits_seen;
    t_phase  last_phase;
    t_tick   drv_tick;
    t_tick   mon_tick;
    t_result mon_want;
    t_result mon_got;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit half_elapsed();
        eng_timer = eng_timer + 1'b1;
        if (eng_timer >= half_ticks) begin
            eng_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_scl_wait wait_for_scl(input logic level);
        if (level) begin
            eng_timer = '0;
            return SCL_WENT_HIGH;
        end
        eng_timer = eng_timer + 1'b1;
        if (eng_timer >= stretch_limit) begin
            eng_timer = '0;
            return SCL_TIMED_OUT;
        end
        return SCL_STILL_LOW;
    endfunction

    function automatic void load_bit();
        if (eng_bit < 4'(BYTE_W))
            eng_sda_low = (eng_cmd == CMD_WRITE) ? ~eng_shift[7] : 1'b0;
        else
            eng_sda_low = (eng_cmd == CMD_READ) ? eng_ack_latch : 1'b0;
        eng_timer = '0;
        eng_phase = PH_BIT_SETUP;
    endfunction

    task automatic step_engine(input t_tick t, output t_result r);
        logic      done;
        logic      err;
        t_scl_wait w;
        done = 1'b0;
        err  = 1'b0;
        case (eng_phase)
            PH_IDLE: begin
                eng_timer = '0;
                if (t.op == CMD_START) begin
                    eng_sda_low = 1'b0;
                    eng_scl_low = 1'b0;
                    eng_cmd     = CMD_START;
                    eng_phase   = PH_START_WAIT;
                end else if (t.op == CMD_STOP) begin
                    eng_sda_low = 1'b1;
                    eng_cmd     = CMD_STOP;
                    eng_phase   = PH_STOP_SETUP;
                end else if (t.op == CMD_WRITE || t.op == CMD_READ) begin
                    eng_cmd       = t_cmd'(t.op);
                    eng_shift     = (t.op == CMD_WRITE) ? t.tx_byte : 8'h00;
                    eng_ack_latch = t.send_ack;
                    eng_bit       = '0;
                    load_bit();
                end else if (t.op == CMD_RECOVER) begin
                    eng_sda_low = 1'b0;
                    eng_scl_low = 1'b1;
                    eng_pulse   = '0;
                    eng_cmd     = CMD_RECOVER;
                    eng_phase   = PH_REC_LOW;
                end
            end
            PH_START_WAIT: begin
                w = wait_for_scl(t.scl_level);
                if (w == SCL_WENT_HIGH) begin
                    eng_phase = PH_START_HOLD1;
                end else if (w == SCL_TIMED_OUT) begin
                    done = 1'b1;
                    err  = 1'b1;
                end
            end
            PH_START_HOLD1: begin
                if (half_elapsed()) begin
                    eng_sda_low = 1'b1;
                    eng_phase   = PH_START_HOLD2;
                end
            end
            PH_START_HOLD2: begin
                if (half_elapsed()) begin
                    eng_scl_low = 1'b1;
                    done        = 1'b1;
                end
            end
            PH_STOP_SETUP: begin
                if (half_elapsed()) begin
                    eng_scl_low = 1'b0;
                    eng_phase   = PH_STOP_WAIT;
                end
            end
            PH_STOP_WAIT: begin
                if (wait_for_scl(t.scl_level) != SCL_STILL_LOW) begin
                    eng_timer = '0;
                    eng_phase = PH_STOP_HIGH;
                end
            end
            PH_STOP_HIGH: begin
                if (half_elapsed()) begin
                    eng_sda_low = 1'b0;
                    eng_phase   = PH_STOP_FREE;
                end
            end
            PH_STOP_FREE: begin
                if (half_elapsed())
                    done = 1'b1;
            end
            PH_BIT_SETUP: begin
                if (half_elapsed()) begin
                    eng_scl_low = 1'b0;
                    eng_phase   = PH_BIT_WAIT;
                end
            end
            PH_BIT_WAIT: begin
                w = wait_for_scl(t.scl_level);
                if (w == SCL_WENT_HIGH) begin
                    eng_phase = PH_BIT_HIGH;
                end else if (w == SCL_TIMED_OUT) begin
                    if (eng_cmd == CMD_WRITE)
                        eng_ack_seen = 1'b0;
                    done = 1'b1;
                    err  = 1'b1;
                end
            end
            PH_BIT_HIGH: begin
                if (half_elapsed()) begin
                    eng_scl_low = 1'b1;
                    if (eng_bit < 4'(BYTE_W)) begin
                        if (eng_cmd == CMD_READ)
                            eng_shift = {eng_shift[6:0], t.sda_level};
                        else
                            eng_shift = {eng_shift[6:0], 1'b0};
                        eng_bit = eng_bit + 1'b1;
                        load_bit();
                    end else begin
                        if (eng_cmd == CMD_WRITE)
                            eng_ack_seen = ~t.sda_level;
                        else
                            eng_rx = eng_shift;
                        done = 1'b1;
                    end
                end
            end
            PH_REC_LOW: begin
                if (half_elapsed()) begin
                    eng_scl_low = 1'b0;
                    eng_phase   = PH_REC_WAIT;
                end
            end
            PH_REC_WAIT: begin
                if (wait_for_scl(t.scl_level) != SCL_STILL_LOW) begin
                    eng_timer = '0;
                    eng_phase = PH_REC_HIGH;
                end
            end
            PH_REC_HIGH: begin
                if (half_elapsed()) begin
                    eng_pulse = eng_pulse + 1'b1;
                    if (eng_pulse < 4'(RECOVERY_PULSES)) begin
                        eng_scl_low = 1'b1;
                        eng_phase   = PH_REC_LOW;
                    end else begin
                        eng_sda_low = 1'b1;
                        eng_phase   = PH_STOP_SETUP;
                    end
                end
            end
            default: begin
                eng_phase = PH_IDLE;
                eng_cmd   = CMD_NONE;
            end
        endcase
        if (done) begin
            eng_phase = PH_IDLE;
            eng_cmd   = CMD_NONE;
            eng_timer = '0;
        end
        r.scl_pull_low = eng_scl_low;
        r.sda_pull_low = eng_sda_low;
        r.busy_res     = (eng_phase != PH_IDLE);
        r.done_res     = done;
        r.rx_byte      = eng_rx;
        r.ack_seen     = eng_ack_seen;
        r.error_code   = err;
    endtask

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.op        <= CMD_NONE;
            req_if.tx_byte   <= '0;
            req_if.send_ack  <= 1'b0;
            req_if.scl_level <= 1'b1;
            req_if.sda_level <= 1'b1;
        end else if (!req_if.valid || issued == accepted) begin
            if (bus_ticks.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
                drv_tick = bus_ticks.pop_front();
                req_if.valid     <= 1'b1;
                req_if.op        <= drv_tick.op;
                req_if.tx_byte   <= drv_tick.tx_byte;
                req_if.send_ack  <= drv_tick.send_ack;
                req_if.scl_level <= drv_tick.scl_level;
                req_if.sda_level <= drv_tick.sda_level;
                issued = issued + 1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        res_if.ready <= rst_n && (no_idle || $urandom_range(99) >= 37);
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                mon_got.scl_pull_low = res_if.scl_pull_low;
                mon_got.sda_pull_low = res_if.sda_pull_low;
                mon_got.busy_res     = res_if.busy_res;
                mon_got.done_res     = res_if.done_res;
                mon_got.rx_byte      = res_if.rx_byte;
                mon_got.ack_seen     = res_if.ack_seen;
                mon_got.error_code   = res_if.error_code;
                if (due_outputs.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("result %0d arrived with no tick pending: %p", res_count,
                                 mon_got);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    mon_want = due_outputs.pop_front();
                    if (mon_got.scl_pull_low !== mon_want.scl_pull_low ||
                        mon_got.sda_pull_low !== mon_want.sda_pull_low ||
                        mon_got.busy_res     !== mon_want.busy_res     ||
                        mon_got.done_res     !== mon_want.done_res     ||
                        mon_got.rx_byte      !== mon_want.rx_byte      ||
                        mon_got.ack_seen     !== mon_want.ack_seen     ||
                        mon_got.error_code   !== mon_want.error_code) begin
                        if (fail_cnt < 10)
                            $display("result %0d mismatch: expected %p, got %p", res_count,
                                     mon_want, mon_got);
                        fail_cnt = fail_cnt + 1;
                    end
                end
                res_count = res_count + 1;
            end
            if (req_if.valid && req_if.ready) begin
                mon_tick.op        = req_if.op;
                mon_tick.tx_byte   = req_if.tx_byte;
                mon_tick.send_ack  = req_if.send_ack;
                mon_tick.scl_level = req_if.scl_level;
                mon_tick.sda_level = req_if.sda_level;
                step_engine(mon_tick, mon_want);
                due_outputs.push_back(mon_want);
                accepted = accepted + 1;
            end
        end
    end

    function automatic int pick_stuck(input int waits);
        if ($urandom_range(99) < 6)
            return $urandom_range(waits - 1, 0);
        return NO_STUCK;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [7:0] tx, input logic ack,
                             input int stuck);
        t_cmd_req c;
        c.op         = op;
        c.tx         = tx;
        c.ack        = ack;
        c.stuck_wait = stuck;
        c.gap        = $urandom_range(2);
        cmd_plan.push_back(c);
    endtask

    task automatic queue_transaction();
        int r;
        int n;
        int k;
        r = $urandom_range(99);
        if (r < 65) begin
            queue_cmd(CMD_START, 8'($urandom), 1'($urandom), pick_stuck(1));
            queue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_stuck(9));
            n = $urandom_range(3);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(1))
                    queue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_stuck(9));
                else
                    queue_cmd(CMD_READ, 8'($urandom), 1'($urandom), pick_stuck(9));
            end
            if ($urandom_range(9) != 0)
                queue_cmd(CMD_STOP, 8'($urandom), 1'($urandom), pick_stuck(1));
        end else if (r < 75) begin
            queue_cmd(CMD_RECOVER, 8'($urandom), 1'($urandom), pick_stuck(10));
        end else if (r < 90) begin
            queue_cmd(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom), pick_stuck(9));
        end else begin
            queue_cmd(CMD_START, 8'($urandom), 1'($urandom), NO_STUCK);
            queue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_stuck(9));
            queue_cmd(CMD_START, 8'($urandom), 1'($urandom), pick_stuck(1));
            queue_cmd(CMD_READ, 8'($urandom), 1'($urandom), pick_stuck(9));
            queue_cmd(CMD_STOP, 8'($urandom), 1'($urandom), NO_STUCK);
        end
    endtask

    // feed ticks one at a time so the bus levels track the engine drives
    task automatic run_commands();
        t_tick    t;
        t_cmd_req c;
        int       eff_to;
        int       short_max;
        bit       hold_low;
        while (cmd_plan.size() != 0 || eng_phase != PH_IDLE) begin
            @(posedge clk);
            #1;
            if (bus_ticks.size() != 0 || issued != accepted)
                continue;
            eff_to      = (stretch_limit == 0) ? 1 : int'(stretch_limit);
            t.op        = CMD_NONE;
            t.tx_byte   = 8'($urandom);
            t.send_ack  = 1'($urandom);
            t.sda_level = 1'($urandom);
            if (eng_phase == PH_IDLE) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    case ($urandom_range(2))
                        0: t.op = CMD_NONE;
                        1: t.op = OP_RSVD6;
                        default: t.op = OP_RSVD7;
                    endcase
                end else if (cmd_plan.size() != 0) begin
                    c          = cmd_plan.pop_front();
                    t.op       = c.op;
                    t.tx_byte  = c.tx;
                    t.send_ack = c.ack;
                    stuck_at   = c.stuck_wait;
                    waits_seen = 0;
                    gap_left   = c.gap;
                end
            end else if ($urandom_range(3) == 0) begin
                t.op = 3'($urandom_range(7));
            end
            if (eng_phase inside {PH_START_WAIT, PH_BIT_WAIT, PH_STOP_WAIT, PH_REC_WAIT} &&
                eng_phase != last_phase) begin
                if (stretch_left == 0) begin
                    if (waits_seen == stuck_at) begin
                        stretch_left = eff_to + $urandom_range(2);
                    end else if (eff_to > 1 && $urandom_range(99) < 12) begin
                        short_max = (eff_to - 1 < 6) ? eff_to - 1 : 6;
                        if (eff_to <= 32 && $urandom_range(1))
                            stretch_left = eff_to - 1;
                        else
                            stretch_left = $urandom_range(short_max, 1);
                    end
                end
                waits_seen = waits_seen + 1;
            end
            hold_low = (stretch_left > 0);
            if (hold_low) begin
                t.scl_level  = 1'b0;
                stretch_left = stretch_left - 1;
            end else begin
                t.scl_level = ~eng_scl_low;
                if ($urandom_range(99) < 2)
                    t.scl_level = ~t.scl_level;
            end
            last_phase = eng_phase;
            bus_ticks.push_back(t);
            gen_ticks = gen_ticks + 1;
        end
    endtask

    task automatic drain_and_settle();
        @(posedge clk);
        #1;
        while (bus_ticks.size() != 0 || issued != accepted || due_outputs.size() != 0) begin
            @(posedge clk);
            #1;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] val);
        repeat ($urandom_range(3)) @(negedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        if (idx == REG_HALF_PERIOD)
            half_ticks = val;
        else if (idx == REG_TIMEOUT)
            stretch_limit = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [TIMER_W-1:0] hp, input logic [TIMER_W-1:0] to);
        write_reg(REG_HALF_PERIOD, hp);
        write_reg(REG_TIMEOUT, to);
    endtask

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int p;
        int base;
        rst_n            = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_HALF_PERIOD;
        cfg_if.data      = '0;
        issued        = 0;
        accepted      = 0;
        res_count     = 0;
        fail_cnt      = 0;
        gen_ticks     = 0;
        no_idle       = 1'b0;
        gap_left      = 0;
        stretch_left  = 0;
        stuck_at      = NO_STUCK;
        waits_seen    = 0;
        last_phase    = PH_IDLE;
        eng_phase     = PH_IDLE;
        eng_timer     = '0;
        eng_bit       = '0;
        eng_shift     = '0;
        eng_pulse     = '0;
        eng_cmd       = CMD_NONE;
        eng_scl_low   = 1'b0;
        eng_sda_low   = 1'b0;
        eng_ack_latch = 1'b0;
        eng_rx        = '0;
        eng_ack_seen  = 1'b0;
        half_ticks    = HALF_PERIOD_RESET;
        stretch_limit = TIMEOUT_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset timing: start, stop, unknown ops and a start on a stuck clock
        queue_cmd(CMD_START, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(OP_RSVD6, 8'hFF, 1'b1, NO_STUCK);
        queue_cmd(OP_RSVD7, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_START, 8'h00, 1'b0, 0);
        run_commands();
        drain_and_settle();

        // every command, plus stuck clocks in stop, write, read and recover
        apply_setting(12'd3, 12'd8);
        queue_cmd(CMD_START, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_WRITE, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_WRITE, 8'hFF, 1'b1, NO_STUCK);
        queue_cmd(CMD_READ, 8'h00, 1'b1, NO_STUCK);
        queue_cmd(CMD_READ, 8'hFF, 1'b0, NO_STUCK);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, 0);
        queue_cmd(CMD_WRITE, 8'hA5, 1'b0, 3);
        queue_cmd(CMD_READ, 8'h00, 1'b1, 8);
        queue_cmd(CMD_RECOVER, 8'h00, 1'b0, 4);
        queue_cmd(CMD_RECOVER, 8'hFF, 1'b1, NO_STUCK);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, NO_STUCK);
        run_commands();
        drain_and_settle();

        // unused indexes must leave both registers alone
        write_reg(REG_UNUSED2, 12'hFFF);
        write_reg(REG_UNUSED3, 12'h000);
        apply_setting(12'h000, 12'h000);
        write_reg(REG_UNUSED3, 12'hFFF);
        write_reg(REG_UNUSED2, 12'h000);
        queue_cmd(CMD_START, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_WRITE, 8'h5A, 1'b0, NO_STUCK);
        queue_cmd(CMD_READ, 8'h00, 1'b1, NO_STUCK);
        queue_cmd(CMD_WRITE, 8'hC3, 1'b0, 0);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, NO_STUCK);
        run_commands();
        drain_and_settle();

        apply_setting(12'd1, 12'd1);
        queue_cmd(CMD_START, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_WRITE, 8'h81, 1'b0, NO_STUCK);
        queue_cmd(CMD_READ, 8'h00, 1'b0, NO_STUCK);
        queue_cmd(CMD_RECOVER, 8'h00, 1'b0, NO_STUCK);
        run_commands();
        drain_and_settle();

        for (p = 0; p < 6; p++) begin
            no_idle = (p == 2);
            if (p == 5)
                apply_setting(12'($urandom_range(12, 5)), 12'($urandom_range(40, 1)));
            else
                apply_setting(12'($urandom_range(4, 1)), 12'($urandom_range(24, 1)));
            base = gen_ticks;
            while (gen_ticks - base < 90) begin
                queue_transaction();
                run_commands();
            end
            drain_and_settle();
        end
        no_idle = 1'b0;

        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && due_outputs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
